FILE: rtl/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared widths, result codes and controller/datapath interface types for the
// sorted timer expiry queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int EXP_W  = 32;
  localparam int TID_W  = 16;
  localparam int TIME_W = 64;
  localparam int KIND_W = 2;
  localparam int IN_DATA_W = EXP_W + TID_W + TIME_W;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

  typedef struct packed {
    logic              load;
    logic              insert;
    logic              pop;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              last;
  } stq_cmd_t;

  typedef struct packed {
    logic out_free;
    logic full;
    logic head_exp;
    logic next_exp;
  } stq_sts_t;

endpackage
`default_nettype wire

FILE: rtl/stq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_ctrl
// Controller that sequences one register or tick item at a time and issues
// load, insert, pop and emit commands to the datapath.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_tvalid,
  input  wire                logic in_operation,
  input  wire                stq_pkg::stq_sts_t sts,
  output logic               in_tready,
  output stq_pkg::stq_cmd_t  cmd
);
  import stq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_INSERT = 3'b010,
    S_TICK   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_operation == OP_TICK) ? S_TICK : S_INSERT;
        end
      end
      S_INSERT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
          if (sts.full) begin
            cmd.kind = KIND_FULL;
          end else begin
            cmd.insert = 1'b1;
            cmd.kind   = KIND_ACCEPTED;
          end
        end
      end
      S_TICK: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.head_exp) begin
            cmd.pop  = 1'b1;
            cmd.kind = KIND_WOKEN;
            cmd.last = !sts.next_exp;
            if (!sts.next_exp) begin
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.kind  = KIND_NONE;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/stq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_datapath
// Row of sorted timer cells with parallel insert compare and pop shift, the
// item holding registers and the output register.
// ----------------------------------------------------------------------------
module stq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                stq_pkg::stq_cmd_t cmd,
  input  wire                logic [stq_pkg::EXP_W-1:0]  in_expire_time,
  input  wire                logic [stq_pkg::TID_W-1:0]  in_task_id,
  input  wire                logic [stq_pkg::TIME_W-1:0] in_current_time,
  input  wire                logic out_tready,
  output stq_pkg::stq_sts_t  sts,
  output logic               out_tvalid,
  output logic [stq_pkg::KIND_W-1:0] out_kind,
  output logic [stq_pkg::TID_W-1:0]  out_task,
  output logic               out_last
);
  import stq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [EXP_W-1:0]  exp_r [DEPTH];
  logic [TID_W-1:0]  tid_r [DEPTH];
  logic [CW-1:0]     count_r, count_nxt;
  logic [EXP_W-1:0]  new_exp_r;
  logic [TID_W-1:0]  new_tid_r;
  logic [TIME_W-1:0] now_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [TID_W-1:0]  out_task_r;
  logic              out_last_r;

  logic [DEPTH-1:0]  ins;
  logic [DEPTH-1:0]  prev_ins;
  logic [EXP_W-1:0]  prev_exp [DEPTH];
  logic [TID_W-1:0]  prev_tid [DEPTH];
  logic [EXP_W-1:0]  next_exp [DEPTH];
  logic [TID_W-1:0]  next_tid [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ins[i] = ((CW'(i) < count_r) && (exp_r[i] >= new_exp_r)) ||
                    (CW'(i) == count_r);

    if (i == 0) begin : g_head
      assign prev_ins[i] = 1'b0;
      assign prev_exp[i] = new_exp_r;
      assign prev_tid[i] = new_tid_r;
    end else begin : g_body
      assign prev_ins[i] = ins[i-1];
      assign prev_exp[i] = exp_r[i-1];
      assign prev_tid[i] = tid_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_exp[i] = exp_r[i];
      assign next_tid[i] = tid_r[i];
    end else begin : g_inner
      assign next_exp[i] = exp_r[i+1];
      assign next_tid[i] = tid_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && ins[i]) begin
        exp_r[i] <= prev_ins[i] ? prev_exp[i] : new_exp_r;
        tid_r[i] <= prev_ins[i] ? prev_tid[i] : new_tid_r;
      end else if (cmd.pop) begin
        exp_r[i] <= next_exp[i];
        tid_r[i] <= next_tid[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_exp_r <= in_expire_time;
      new_tid_r <= in_task_id;
      now_r     <= in_current_time;
    end
    if (cmd.emit) begin
      out_kind_r <= cmd.kind;
      out_task_r <= cmd.pop ? tid_r[0] : '0;
      out_last_r <= cmd.last;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.full     = (count_r == CW'(DEPTH));
  assign sts.head_exp = (count_r != '0) && (TIME_W'(exp_r[0]) <= now_r);

  if (DEPTH > 1) begin : g_next
    assign sts.next_exp = (count_r > CW'(1)) && (TIME_W'(exp_r[1]) <= now_r);
  end else begin : g_single
    assign sts.next_exp = 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_task   = out_task_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/sorted_timer_expiry_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_expiry_queue
// Up to DEPTH pending timers kept sorted by expiry; ticks release expired ones.
// ----------------------------------------------------------------------------
// Items enter on the in_ channel. in_tuser selects the operation: a register
// item inserts its expiry time and task id ahead of stored timers with equal
// or later expiry, or is rejected with a full status. A tick item removes all
// timers with expiry not later than its current time and returns their task
// ids in expiry order, or a single none status if nothing has expired.
// Results leave on the out_ channel with the kind on out_tuser, the task id on
// out_tdata and out_tlast on the final result of each item.
// A register item passes through the idle and insert states; a tick item stays
// in the tick state while expired timers remain, one expired timer popped from
// the head of the cell row per cycle while the output register is free. The
// first result is written to the output register from the insert or tick
// state. The next input is taken once the last result of the current item is
// in the output register. While the receiver stalls, the held result stays put
// and the queue waits. Reset empties the queue; there is no clearing pass.
// ----------------------------------------------------------------------------
module sorted_timer_expiry_queue #(
  parameter int DEPTH = 16
) (
  input  wire  logic         clk,
  input  wire  logic         rst_n,
  input  wire  logic         in_tvalid,
  output logic               in_tready,
  // Fields from bit 0: expire_time[31:0], task_id[47:32], current_time[111:48].
  input  wire  logic [stq_pkg::IN_DATA_W-1:0] in_tdata,
  // Fields from bit 0: operation.
  input  wire  logic         in_tuser,
  output logic               out_tvalid,
  input  wire  logic         out_tready,
  // Fields from bit 0: woken_task.
  output logic [stq_pkg::TID_W-1:0] out_tdata,
  // Fields from bit 0: kind.
  output logic [stq_pkg::KIND_W-1:0] out_tuser,
  output logic               out_tlast
);
  import stq_pkg::*;

  stq_cmd_t cmd;
  stq_sts_t sts;

  stq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_operation (in_tuser),
    .sts          (sts),
    .in_tready    (in_tready),
    .cmd          (cmd)
  );

  stq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_expire_time  (in_tdata[EXP_W-1:0]),
    .in_task_id      (in_tdata[EXP_W+TID_W-1:EXP_W]),
    .in_current_time (in_tdata[IN_DATA_W-1:EXP_W+TID_W]),
    .out_tready      (out_tready),
    .sts             (sts),
    .out_tvalid      (out_tvalid),
    .out_kind        (out_tuser),
    .out_task        (out_tdata),
    .out_last        (out_tlast)
  );

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !sts.full)
    else $error("Insert issued while the queue is full.");

  a_pop_only_expired: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> sts.head_exp)
    else $error("Pop issued for a timer that has not expired.");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_ACCEPTED || out_tuser == KIND_FULL ||
                    out_tuser == KIND_NONE)) |-> (out_tlast && out_tdata == '0))
    else $error("Status result without last or with a nonzero task id.");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("Result written over a pending output.");

endmodule
`default_nettype wire

FILE: test/tb_sorted_timer_expiry_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sorted_timer_expiry_queue
// Self-checking testbench for the sorted timer expiry queue.
// ----------------------------------------------------------------------------
// A short directed table covers an empty queue, the extremes of every field,
// timers with equal expiry, head and tail insertion, a full queue and ticks
// that release one, several or all timers. A random part follows. It alternates
// between bursts that fill the queue and bursts that drain it. A local model
// of the sorted store predicts every result transfer, and a monitor compares
// each one with the oldest prediction. Both sides of the block idle in random
// bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_sorted_timer_expiry_queue;
  import stq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 100;
  localparam int QUIET_ITEMS  = 20;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  tid;
    logic              last;
  } wake_result_t;

  typedef struct {
    logic              op;
    logic [EXP_W-1:0]  exp_time;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] now;
    bit                typed;
    logic [KIND_W-1:0] kind;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic                 in_tuser = OP_REGISTER;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TID_W-1:0]     out_tdata;
  logic [KIND_W-1:0]    out_tuser;
  logic                 out_tlast;

  logic [EXP_W-1:0] timer_exp [DEPTH];
  logic [TID_W-1:0] timer_tid [DEPTH];
  int               timer_cnt = 0;

  wake_result_t pending [$];
  stim_row_t    directed [$];

  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  n_accepted = 0;
  int  n_full = 0;
  int  n_woken = 0;
  int  n_none = 0;
  int  stall_left = 0;
  bit  quiet_phase = 1'b0;

  sorted_timer_expiry_queue #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (errors < 20) begin
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    end
    errors++;
  endtask

  // Updates the local timer store for one input and returns its result transfers.
  function automatic void advance_timers(input logic op, input logic [EXP_W-1:0] exp_time,
                                         input logic [TID_W-1:0] tid,
                                         input logic [TIME_W-1:0] now,
                                         ref wake_result_t results [$]);
    int pos;
    int n;
    results.delete();
    if (op == OP_REGISTER) begin
      if (timer_cnt >= DEPTH) begin
        results.push_back('{KIND_FULL, '0, 1'b1});
        return;
      end
      pos = timer_cnt;
      for (int i = 0; i < timer_cnt; i++) begin
        if (timer_exp[i] >= exp_time) begin
          pos = i;
          break;
        end
      end
      for (int i = timer_cnt; i > pos; i--) begin
        timer_exp[i] = timer_exp[i-1];
        timer_tid[i] = timer_tid[i-1];
      end
      timer_exp[pos] = exp_time;
      timer_tid[pos] = tid;
      timer_cnt++;
      results.push_back('{KIND_ACCEPTED, '0, 1'b1});
    end else begin
      n = 0;
      while (n < timer_cnt && {32'd0, timer_exp[n]} <= now) n++;
      if (n == 0) begin
        results.push_back('{KIND_NONE, '0, 1'b1});
        return;
      end
      for (int i = 0; i < n; i++) begin
        results.push_back('{KIND_WOKEN, timer_tid[i], (i == n - 1)});
      end
      for (int i = n; i < timer_cnt; i++) begin
        timer_exp[i-n] = timer_exp[i];
        timer_tid[i-n] = timer_tid[i];
      end
      timer_cnt -= n;
    end
  endfunction

  task automatic offer_item(input logic op, input logic [EXP_W-1:0] exp_time,
                            input logic [TID_W-1:0] tid, input logic [TIME_W-1:0] now);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {now, tid, exp_time};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic void add_row(input logic op, input logic [EXP_W-1:0] exp_time,
                                  input logic [TID_W-1:0] tid,
                                  input logic [TIME_W-1:0] now, input bit typed,
                                  input logic [KIND_W-1:0] kind);
    stim_row_t row;
    row.op       = op;
    row.exp_time = exp_time;
    row.tid      = tid;
    row.now      = now;
    row.typed    = typed;
    row.kind     = kind;
    directed.push_back(row);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    wake_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      case (out_tuser)
        KIND_ACCEPTED: n_accepted++;
        KIND_FULL:     n_full++;
        KIND_WOKEN:    n_woken++;
        default:       n_none++;
      endcase
      if (pending.size() == 0) begin
        flag_mismatch("unexpected result, kind", 32'(out_tuser), 0);
      end else begin
        want = pending.pop_front();
        if (out_tuser !== want.kind) flag_mismatch("kind", 32'(out_tuser), 32'(want.kind));
        if (out_tdata !== want.tid) flag_mismatch("woken task", 32'(out_tdata), 32'(want.tid));
        if (out_tlast !== want.last) flag_mismatch("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    wake_result_t      results [$];
    logic              op;
    logic [EXP_W-1:0]  exp_time;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] time_base;
    int                reg_pct;

    add_row(OP_TICK,     32'd0,          16'h0000, 64'd0,      1, KIND_NONE);
    add_row(OP_TICK,     32'hFFFF_FFFF,  16'hFFFF, '1,         1, KIND_NONE);
    add_row(OP_REGISTER, 32'd0,          16'h0000, '1,         1, KIND_ACCEPTED);
    add_row(OP_REGISTER, 32'hFFFF_FFFF,  16'hFFFF, 64'd0,      1, KIND_ACCEPTED);
    add_row(OP_REGISTER, 32'd5,          16'h1234, 64'd0,      1, KIND_ACCEPTED);
    add_row(OP_REGISTER, 32'd5,          16'h5678, 64'd0,      1, KIND_ACCEPTED);
    add_row(OP_TICK,     32'd0,          16'h0000, 64'd4,      0, KIND_NONE);
    add_row(OP_TICK,     32'd0,          16'h0000, 64'd5,      0, KIND_NONE);
    add_row(OP_TICK,     32'd0,          16'h0000, 64'h1_0000_0000, 0, KIND_NONE);
    for (int i = 0; i < DEPTH; i++) begin
      add_row(OP_REGISTER, (i < 8) ? 32'd1000 - 10 * i : 32'd1000 + (i % 3),
              TID_W'(32'h0100 + i), 64'd0, 1, KIND_ACCEPTED);
    end
    add_row(OP_REGISTER, 32'd0,          16'hBEEF, 64'd0,      1, KIND_FULL);
    add_row(OP_TICK,     32'd0,          16'h0000, 64'd990,    0, KIND_NONE);
    add_row(OP_TICK,     32'd0,          16'h0000, '1,         0, KIND_NONE);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r]) begin
      offer_item(directed[r].op, directed[r].exp_time, directed[r].tid, directed[r].now);
      advance_timers(directed[r].op, directed[r].exp_time, directed[r].tid, directed[r].now,
                     results);
      if (directed[r].typed) begin
        pending.push_back('{directed[r].kind, '0, 1'b1});
      end else begin
        foreach (results[j]) pending.push_back(results[j]);
      end
    end

    time_base = 64'd10000;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      quiet_phase = (k >= RANDOM_ITEMS - QUIET_ITEMS);
      reg_pct = ((k / 20) % 2 == 0) ? 85 : 40;
      if ($urandom_range(0, 99) < reg_pct) begin
        op  = OP_REGISTER;
        tid = TID_W'($urandom);
        now = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) begin
          exp_time = $urandom;
        end else begin
          exp_time = time_base[EXP_W-1:0] + $urandom_range(0, 300);
        end
      end else begin
        op       = OP_TICK;
        exp_time = $urandom;
        tid      = TID_W'($urandom);
        case ($urandom_range(0, 9))
          0:       now = {$urandom, $urandom};
          1:       now = '0;
          default: now = time_base + $urandom_range(0, 150);
        endcase
        time_base = time_base + $urandom_range(0, 100);
      end
      offer_item(op, exp_time, tid, now);
      advance_timers(op, exp_time, tid, now, results);
      foreach (results[j]) pending.push_back(results[j]);
    end
    in_tvalid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d items: %0d directed rows, %0d random", items_sent, directed.size(),
             RANDOM_ITEMS);
    $display("results seen: %0d accepted, %0d full, %0d woken, %0d none expired",
             n_accepted, n_full, n_woken, n_none);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/stq_pkg.sv
rtl/stq_ctrl.sv
rtl/stq_datapath.sv
rtl/sorted_timer_expiry_queue.sv
test/tb_sorted_timer_expiry_queue.sv
